// ===== hw/rtl/two_point_similarity_fit_top_assert.svh =====
// Assertion macros for the two-point similarity fit block
`ifndef TWO_POINT_SIMILARITY_FIT_TOP_ASSERT_SVH
`define TWO_POINT_SIMILARITY_FIT_TOP_ASSERT_SVH

// condition checked at every edge outside reset
`define TPSF_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define TPSF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/tpsf_pkg.sv =====
// Shared constants and types of the two-point similarity fit block
`timescale 1ns / 1ps
package tpsf_pkg;

  localparam int RemW  = 67;
  localparam int QuoW  = 34;
  localparam int NumCells = QuoW;
  localparam int DenW  = 34;

  localparam logic [1:0] TAG_A  = 2'd0;
  localparam logic [1:0] TAG_B  = 2'd1;
  localparam logic [1:0] TAG_TX = 2'd2;
  localparam logic [1:0] TAG_TY = 2'd3;

  typedef struct packed {
    logic [1:0]      tag;
    logic            sign;
    logic            deg;
    logic [RemW-1:0] rem;
    logic [RemW-1:0] dsh;
    logic [QuoW-1:0] quo;
  } div_word_t;

endpackage

// ===== hw/rtl/tpsf_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and hands on
`timescale 1ns / 1ps
module tpsf_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  tpsf_pkg::div_word_t in_w,
  output logic                out_v,
  output tpsf_pkg::div_word_t out_w
);

  logic                v_r;
  tpsf_pkg::div_word_t w_r, w_nxt;
  logic                ge;

  always_comb begin
    ge = (in_w.rem >= in_w.dsh);
    w_nxt = in_w;
    w_nxt.rem = ge ? (in_w.rem - in_w.dsh) : in_w.rem;
    w_nxt.dsh = in_w.dsh >> 1;
    w_nxt.quo = {in_w.quo[tpsf_pkg::QuoW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign out_v = v_r;
  assign out_w = w_r;

endmodule

// ===== hw/rtl/tpsf_prep.sv =====
// Front pipeline: deltas, products, numerators and division issue
`timescale 1ns / 1ps
module tpsf_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [127:0]        in_tdata,
  input  logic                adv,
  output logic                head_v,
  output tpsf_pkg::div_word_t head_w
);

  // stage 1
  logic               s1_v_r;
  logic signed [16:0] dx_r, dy_r, ddx_r, ddy_r;
  logic signed [15:0] x0_r, y0_r, tx0_r, ty0_r;
  // stage 2
  logic               s2_v_r;
  logic [tpsf_pkg::DenW-1:0] den2_r;
  logic signed [34:0] na2_r, nb2_r;
  logic signed [15:0] x0b_r, y0b_r, tx0b_r, ty0b_r;
  // stage 3
  logic               s3_v_r;
  logic [tpsf_pkg::DenW-1:0] den3_r;
  logic signed [34:0] na3_r, nb3_r;
  logic signed [50:0] ptx_r, pty_r, pnax_r, pnby_r, pnbx_r, pnay_r;
  // stage 4
  logic               s4_v_r;
  logic [tpsf_pkg::DenW-1:0] den4_r;
  logic               deg4_r;
  logic signed [34:0] na4_r, nb4_r;
  logic signed [51:0] ntx4_r, nty4_r;
  logic [1:0]         cnt_r;
  // head
  logic                head_v_r;
  tpsf_pkg::div_word_t head_w_r, head_w_nxt;

  logic s2_free, s3_free, s4_free;
  logic signed [34:0] den_s;
  logic signed [63:0] num;
  logic [63:0]        mag;

  assign s4_free   = !s4_v_r || (cnt_r == tpsf_pkg::TAG_TY && adv);
  assign s3_free   = !s3_v_r || s4_free;
  assign s2_free   = !s2_v_r || s3_free;
  assign in_tready = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      cnt_r  <= tpsf_pkg::TAG_A;
      head_v_r <= 1'b0;
    end else begin
      if (in_tready) s1_v_r <= in_tvalid;
      if (s2_free) s2_v_r <= s1_v_r;
      if (s3_free) s3_v_r <= s2_v_r;
      if (s4_free) s4_v_r <= s3_v_r;
      if (adv) begin
        head_v_r <= s4_v_r;
        if (s4_v_r) cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  assign den_s = $signed({1'b0, den2_r});

  always_comb begin
    case (cnt_r)
      tpsf_pkg::TAG_A:  num = 64'(na4_r) <<< 16;
      tpsf_pkg::TAG_B:  num = 64'(nb4_r) <<< 16;
      tpsf_pkg::TAG_TX: num = 64'(ntx4_r) <<< 12;
      default:          num = 64'(nty4_r) <<< 12;
    endcase
    mag = num[63] ? 64'(-num) : 64'(num);
    head_w_nxt.tag  = cnt_r;
    head_w_nxt.sign = num[63];
    head_w_nxt.deg  = deg4_r;
    head_w_nxt.rem  = tpsf_pkg::RemW'(mag) + tpsf_pkg::RemW'(den4_r >> 1);
    head_w_nxt.dsh  = tpsf_pkg::RemW'(den4_r) << (tpsf_pkg::QuoW - 1);
    head_w_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      dx_r  <= $signed({in_tdata[47], in_tdata[47:32]})   - $signed({in_tdata[15], in_tdata[15:0]});
      dy_r  <= $signed({in_tdata[63], in_tdata[63:48]})   - $signed({in_tdata[31], in_tdata[31:16]});
      ddx_r <= $signed({in_tdata[111], in_tdata[111:96]}) - $signed({in_tdata[79], in_tdata[79:64]});
      ddy_r <= $signed({in_tdata[127], in_tdata[127:112]}) - $signed({in_tdata[95], in_tdata[95:80]});
      x0_r  <= $signed(in_tdata[15:0]);
      y0_r  <= $signed(in_tdata[31:16]);
      tx0_r <= $signed(in_tdata[79:64]);
      ty0_r <= $signed(in_tdata[95:80]);
    end
    if (s2_free) begin
      den2_r <= tpsf_pkg::DenW'(35'(dx_r * dx_r) + 35'(dy_r * dy_r));
      na2_r  <= 35'(dx_r * ddx_r) + 35'(dy_r * ddy_r);
      nb2_r  <= 35'(dx_r * ddy_r) - 35'(dy_r * ddx_r);
      x0b_r  <= x0_r;
      y0b_r  <= y0_r;
      tx0b_r <= tx0_r;
      ty0b_r <= ty0_r;
    end
    if (s3_free) begin
      den3_r <= den2_r;
      na3_r  <= na2_r;
      nb3_r  <= nb2_r;
      ptx_r  <= 51'(tx0b_r * den_s);
      pty_r  <= 51'(ty0b_r * den_s);
      pnax_r <= 51'(na2_r * x0b_r);
      pnby_r <= 51'(nb2_r * y0b_r);
      pnbx_r <= 51'(nb2_r * x0b_r);
      pnay_r <= 51'(na2_r * y0b_r);
    end
    if (s4_free) begin
      deg4_r <= (den3_r == '0);
      den4_r <= (den3_r == '0) ? tpsf_pkg::DenW'(1) : den3_r;
      na4_r  <= na3_r;
      nb4_r  <= nb3_r;
      ntx4_r <= 52'(ptx_r) - 52'(pnax_r) + 52'(pnby_r);
      nty4_r <= 52'(pty_r) - 52'(pnbx_r) - 52'(pnay_r);
    end
    if (adv) begin
      head_w_r <= head_w_nxt;
    end
  end

  assign head_v = head_v_r;
  assign head_w = head_w_r;

endmodule

// ===== hw/rtl/two_point_similarity_fit_top.sv =====
// Top level of the two-point similarity fit block
`timescale 1ns / 1ps
`include "two_point_similarity_fit_top_assert.svh"
// Usage:
//  in_*  : one word per fit, two source and two target points in Q12.4.
//  out_* : one word per fit, a, b, tx, ty in Q16.16 plus flags.
//  A word is taken when tvalid and tready are both high.
//  The four quotients a, b, tx, ty share one chain of 34
//  restoring-division cells, one quotient per cycle while the chain
//  is not stalled. A fit passes 5 front registers (stages 1 to 4 and
//  the head, which issues its four quotients in turn), 34 cells and
//  1 output register; fits overlap in the chain.
//  The output register lets the next fits advance while one result waits.
//  When the receiver stalls with a finished result waiting and the next
//  result is due, the chain, the head and stage 4 hold until out_tready.
//  Reset empties every stage; no item is in flight afterward.
//  Coincident source points give zero coefficients and degenerate set.
module two_point_similarity_fit_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_x0, from_y0, from_x1, from_y1, to_x0, to_y0, to_x1, to_y1 (16 each)
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // scale_cos, scale_sin, shift_x, shift_y (32 each)
  output logic [127:0] out_tdata,
  // degenerate, saturated
  output logic [1:0]   out_tuser
);

  logic                adv;
  logic                v [tpsf_pkg::NumCells+1];
  tpsf_pkg::div_word_t w [tpsf_pkg::NumCells+1];

  logic         out_v_r;
  logic [127:0] out_data_r;
  logic [1:0]   out_user_r;
  logic [31:0]  res_r [3];
  logic         sat_r;

  logic                last_v;
  tpsf_pkg::div_word_t last_w;
  logic                last_done;
  logic                satx;
  logic [31:0]         val;

  assign last_v    = v[tpsf_pkg::NumCells];
  assign last_w    = w[tpsf_pkg::NumCells];
  assign last_done = last_v && last_w.tag == tpsf_pkg::TAG_TY;
  assign adv       = !(out_v_r && !out_tready && last_done);

  tpsf_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .head_v    (v[0]),
    .head_w    (w[0])
  );

  for (genvar k = 0; k < tpsf_pkg::NumCells; k++) begin : g_cell
    tpsf_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .in_v  (v[k]),
      .in_w  (w[k]),
      .out_v (v[k+1]),
      .out_w (w[k+1])
    );
  end

  always_comb begin
    if (last_w.sign) begin
      satx = (last_w.quo[33:32] != 2'b00) || (last_w.quo[31] && last_w.quo[30:0] != '0);
      val  = satx ? 32'h8000_0000 : 32'(-last_w.quo[31:0]);
    end else begin
      satx = (last_w.quo[33:31] != 3'b000);
      val  = satx ? 32'h7fff_ffff : last_w.quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (last_done && adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_v && adv) begin
      case (last_w.tag)
        tpsf_pkg::TAG_A: begin
          res_r[0] <= val;
          sat_r    <= satx;
        end
        tpsf_pkg::TAG_B: begin
          res_r[1] <= val;
          sat_r    <= sat_r | satx;
        end
        tpsf_pkg::TAG_TX: begin
          res_r[2] <= val;
          sat_r    <= sat_r | satx;
        end
        default: begin
          out_data_r <= {val, res_r[2], res_r[1], res_r[0]};
          out_user_r <= {sat_r | satx, last_w.deg};
        end
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `TPSF_ASSERT(a_stall_only_full, !adv |-> out_v_r, "chain stalled with empty output")
  `TPSF_ASSERT_NEXT(a_stall_holds, last_v && !adv, last_v && $stable(last_w.tag), "stalled cell lost")
  `TPSF_ASSERT(a_deg_zero, out_v_r && out_user_r[0] |-> out_data_r == '0 && !out_user_r[1], "degenerate fit with nonzero coefficients")
  `TPSF_ASSERT_NEXT(a_load_valid, last_done && adv, out_v_r, "finished fit not shown")

endmodule
